/* rtl/core/msf_pkg.sv */
// Shared types, constants and the control store for the message slicer framer.
// No dependencies; every other file of the block depends on this package.
package msf_pkg;

   localparam int OP_W   = 1;
   localparam int ADDR_W = 16;
   localparam int LEN_W  = 12;
   localparam int BYTE_W = 8;
   localparam int CRC_W  = 16;

   localparam int SLICE_BYTES_DEF = 12;
   localparam int MAX_LENGTH_DEF  = 3060;

   localparam logic [OP_W-1:0] OP_START = 1'b0;
   localparam logic [OP_W-1:0] OP_DATA  = 1'b1;

   localparam logic [BYTE_W-1:0] HDR_SYNC = 8'h9e;
   localparam logic [BYTE_W-1:0] HDR_LEN  = 8'h18;
   localparam logic [CRC_W-1:0]  CRC_INIT = 16'hffff;
   localparam logic [CRC_W-1:0]  CRC_POLY = 16'ha001;

   // sequencer steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] S_REJ     = 4'd1;
   localparam logic [STEP_W-1:0] S_DIV     = 4'd2;
   localparam logic [STEP_W-1:0] S_HDR0    = 4'd3;
   localparam logic [STEP_W-1:0] S_HDR1    = 4'd4;
   localparam logic [STEP_W-1:0] S_ADDR_HI = 4'd5;
   localparam logic [STEP_W-1:0] S_ADDR_LO = 4'd6;
   localparam logic [STEP_W-1:0] S_DATA    = 4'd7;
   localparam logic [STEP_W-1:0] S_TOTAL   = 4'd8;
   localparam logic [STEP_W-1:0] S_INDEX   = 4'd9;
   localparam logic [STEP_W-1:0] S_CRC_HI  = 4'd10;
   localparam logic [STEP_W-1:0] S_CRC_LO  = 4'd11;

   // byte sources
   localparam int SRC_W = 4;
   localparam logic [SRC_W-1:0] SRC_REJ     = 4'd0;
   localparam logic [SRC_W-1:0] SRC_SYNC    = 4'd1;
   localparam logic [SRC_W-1:0] SRC_LEN     = 4'd2;
   localparam logic [SRC_W-1:0] SRC_ADDR_HI = 4'd3;
   localparam logic [SRC_W-1:0] SRC_ADDR_LO = 4'd4;
   localparam logic [SRC_W-1:0] SRC_DATA    = 4'd5;
   localparam logic [SRC_W-1:0] SRC_TOTAL   = 4'd6;
   localparam logic [SRC_W-1:0] SRC_INDEX   = 4'd7;
   localparam logic [SRC_W-1:0] SRC_CRC_HI  = 4'd8;
   localparam logic [SRC_W-1:0] SRC_CRC_LO  = 4'd9;

   // jump conditions
   localparam int COND_W = 2;
   localparam logic [COND_W-1:0] COND_ALWAYS = 2'd0;
   localparam logic [COND_W-1:0] COND_DATA   = 2'd2;

   // dispatch on an accepted item
   localparam int DISP_W = 2;
   localparam logic [DISP_W-1:0] DISP_NONE  = 2'd0;
   localparam logic [DISP_W-1:0] DISP_REJ   = 2'd1;
   localparam logic [DISP_W-1:0] DISP_DIV   = 2'd2;
   localparam logic [DISP_W-1:0] DISP_FRAME = 2'd3;

   typedef struct packed {
      logic              accept;
      logic              emit;
      logic [SRC_W-1:0]  src;
      logic              crc_init;
      logic              crc_upd;
      logic              div_step;
      logic              cnt_inc;
      logic              frame_done;
      logic              frame_end;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] t_true;
      logic [STEP_W-1:0] t_false;
   } ucode_type;

   typedef struct packed {
      logic              go;
      logic              data_last;
      logic [DISP_W-1:0] disp;
   } dp_status_type;

   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int b = 0; b < BYTE_W; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // control store
   function automatic ucode_type msf_ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      w.cond    = COND_ALWAYS;
      w.t_true  = S_IDLE;
      w.t_false = S_IDLE;
      unique case (step)
         S_IDLE: begin
            w.accept = 1'b1;
         end
         S_REJ: begin
            w.emit = 1'b1; w.src = SRC_REJ; w.frame_end = 1'b1;
         end
         S_DIV: begin
            w.div_step = 1'b1; w.t_true = S_IDLE;
         end
         S_HDR0: begin
            w.emit = 1'b1; w.src = SRC_SYNC; w.crc_init = 1'b1; w.t_true = S_HDR1;
         end
         S_HDR1: begin
            w.emit = 1'b1; w.src = SRC_LEN; w.t_true = S_ADDR_HI;
         end
         S_ADDR_HI: begin
            w.emit = 1'b1; w.src = SRC_ADDR_HI; w.t_true = S_ADDR_LO;
         end
         S_ADDR_LO: begin
            w.emit = 1'b1; w.src = SRC_ADDR_LO; w.t_true = S_DATA;
         end
         S_DATA: begin
            w.emit = 1'b1; w.src = SRC_DATA; w.crc_upd = 1'b1; w.cnt_inc = 1'b1;
            w.cond = COND_DATA; w.t_true = S_TOTAL; w.t_false = S_DATA;
         end
         S_TOTAL: begin
            w.emit = 1'b1; w.src = SRC_TOTAL; w.crc_upd = 1'b1; w.t_true = S_INDEX;
         end
         S_INDEX: begin
            w.emit = 1'b1; w.src = SRC_INDEX; w.crc_upd = 1'b1; w.t_true = S_CRC_HI;
         end
         S_CRC_HI: begin
            w.emit = 1'b1; w.src = SRC_CRC_HI; w.t_true = S_CRC_LO;
         end
         S_CRC_LO: begin
            w.emit = 1'b1; w.src = SRC_CRC_LO; w.frame_end = 1'b1;
            w.frame_done = 1'b1;
         end
         default: begin
            w.t_true = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/msf_chan_if.sv */
// Valid/ready channel interfaces for the request and response items.
// Depends on msf_pkg for the field widths.
interface msf_req_if;
   logic                         valid;
   logic                         ready;
   logic [msf_pkg::OP_W-1:0]     op;
   logic [msf_pkg::ADDR_W-1:0]   dest_addr;
   logic [msf_pkg::LEN_W-1:0]    msg_length;
   logic [msf_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output op, output dest_addr, output msg_length,
                   output data_byte, input ready);
   modport sink   (input valid, input op, input dest_addr, input msg_length,
                   input data_byte, output ready);
endinterface

interface msf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [msf_pkg::BYTE_W-1:0]   out_byte;
   logic                         kind;
   logic                         frame_end;

   modport source (output valid, output out_byte, output kind, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input kind, input frame_end,
                   output ready);
endinterface

/* rtl/core/message_slicer_crc16_framer_top.sv */
// Message slicer framer: top level joining the microcode sequencer and datapath.
// Depends on msf_pkg, msf_chan_if, msf_seq and msf_dp.
//
// A start item (op 0) opens a message for an address and a length; the message
// bytes then follow one per item. Every SLICE_BYTES bytes, and on the last byte
// of the message, a frame of SLICE_BYTES + 8 bytes leaves one byte per item:
// 0x9E, 0x18, address high, address low, the slice (zero padded), slice count,
// slice number from 1 and a Modbus CRC16, high byte first. A start with a length
// of 0 or of MAX_LENGTH or more gives a single item with kind set. Timing is set
// by the microcode sequencer, which works on one item at a time: a data byte that
// does not close a slice is taken alone; one that closes it is followed by one step
// per frame byte, each held while the output register is full; a valid start is
// followed by one step that works out the slice count by a reciprocal multiply; a
// rejection is followed by one step that emits the rejection item.
module message_slicer_crc16_framer_top #(
   parameter int SLICE_BYTES = msf_pkg::SLICE_BYTES_DEF,
   parameter int MAX_LENGTH  = msf_pkg::MAX_LENGTH_DEF
) (
   input logic       clock,
   input logic       reset,
   msf_req_if.sink   req_chan,
   msf_rsp_if.source rsp_chan
);
   import msf_pkg::*;

   ucode_type         cw;
   dp_status_type     status;
   logic [STEP_W-1:0] step;

   msf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw),
      .step   (step)
   );

   msf_dp #(
      .SLICE_BYTES (SLICE_BYTES),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cw       (cw),
      .status   (status)
   );

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (step != S_IDLE) |-> !req_chan.ready)
      else $error("item taken while sequencer busy");

   a_frame_closes: assert property (@(posedge clock) disable iff (reset)
      (step == S_CRC_LO) && status.go |=> (step == S_IDLE))
      else $error("frame did not return to idle");

   a_reject_path: assert property (@(posedge clock) disable iff (reset)
      (step == S_IDLE) && req_chan.valid && (req_chan.op == OP_START) &&
      (req_chan.msg_length == '0) |=> (step == S_REJ))
      else $error("zero length start not rejected");
`endif

endmodule

/* rtl/core/msf_seq.sv */
// Microcode sequencer: step register, control store lookup and jump logic.
// Depends on msf_pkg.
module msf_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  msf_pkg::dp_status_type status,
   output msf_pkg::ucode_type     cw,
   output logic [msf_pkg::STEP_W-1:0] step
);
   import msf_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   assign cw   = msf_ucode(step_ff);
   assign step = step_ff;

   always_comb begin
      step_in = step_ff;
      if (status.go) begin
         if (cw.accept) begin
            unique case (status.disp)
               DISP_NONE:  step_in = S_IDLE;
               DISP_REJ:   step_in = S_REJ;
               DISP_DIV:   step_in = S_DIV;
               DISP_FRAME: step_in = S_HDR0;
            endcase
         end else begin
            unique case (cw.cond)
               COND_ALWAYS: step_in = cw.t_true;
               COND_DATA:   step_in = status.data_last ? cw.t_true : cw.t_false;
               default:     step_in = cw.t_false;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* rtl/core/msf_dp.sv */
// Datapath: slice buffer, message counters, slice-count divider, CRC16 and
// the output register. Driven by the control word from msf_seq; uses msf_pkg.
module msf_dp #(
   parameter int SLICE_BYTES = msf_pkg::SLICE_BYTES_DEF,
   parameter int MAX_LENGTH  = msf_pkg::MAX_LENGTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   msf_req_if.sink                req_chan,
   msf_rsp_if.source              rsp_chan,
   input  msf_pkg::ucode_type     cw,
   output msf_pkg::dp_status_type status
);
   import msf_pkg::*;

   localparam int DIVD_W = $clog2((1 << LEN_W) + SLICE_BYTES - 1);
   localparam int FILL_W = $clog2(SLICE_BYTES + 1);
   localparam int IDX_W  = (SLICE_BYTES > 1) ? $clog2(SLICE_BYTES) : 1;
   localparam int CNT_W  = $clog2(SLICE_BYTES + 1);
   localparam int RCP_SH = DIVD_W + $clog2(SLICE_BYTES);
   localparam int RCP_W  = DIVD_W + 1;
   localparam int PROD_W = DIVD_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP_M =
      RCP_W'(((1 << RCP_SH) + SLICE_BYTES - 1) / SLICE_BYTES);
   localparam logic [LEN_W:0] MAX_LEN_V = (LEN_W+1)'(MAX_LENGTH);

   logic [BYTE_W-1:0] mem [SLICE_BYTES];
   logic [BYTE_W-1:0] rd_ff;
   logic [IDX_W-1:0]  rd_addr;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] index_ff, index_in;
   logic              active_ff, active_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              kind_ff, kind_in;
   logic              frame_end_ff, frame_end_in;

   logic              slot_free;
   logic              acc_fire;
   logic              emit_fire;
   logic              bad_len;
   logic              slice_last;
   logic              data_ok;
   logic [BYTE_W-1:0] byte_sel;
   logic [PROD_W-1:0] div_prod;
   logic [DISP_W-1:0] disp_sel;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign acc_fire  = cw.accept && req_chan.valid;
   assign emit_fire = cw.emit && slot_free;
   assign req_chan.ready = cw.accept;

   assign bad_len    = (req_chan.msg_length == '0) ||
                       ({1'b0, req_chan.msg_length} >= MAX_LEN_V);
   assign data_ok    = (req_chan.op == OP_DATA) && active_ff;
   assign slice_last = (fill_ff == FILL_W'(SLICE_BYTES - 1)) || (left_ff == LEN_W'(1));

   assign status.go        = cw.accept ? req_chan.valid : (cw.emit ? slot_free : 1'b1);
   assign status.data_last = (cnt_ff == CNT_W'(SLICE_BYTES - 1));
   assign status.disp      = disp_sel;

   always_comb begin
      priority if (req_chan.op == OP_START) begin
         disp_sel = bad_len ? DISP_REJ : DISP_DIV;
      end else if (data_ok && slice_last) begin
         disp_sel = DISP_FRAME;
      end else begin
         disp_sel = DISP_NONE;
      end
   end

   // slice count as floor((len + SLICE_BYTES - 1) / SLICE_BYTES) by reciprocal multiply
   assign div_prod = PROD_W'(quo_ff) * PROD_W'(RCP_M);

   always_comb begin
      unique case (cw.src)
         SRC_REJ:     byte_sel = '0;
         SRC_SYNC:    byte_sel = HDR_SYNC;
         SRC_LEN:     byte_sel = HDR_LEN;
         SRC_ADDR_HI: byte_sel = addr_ff[ADDR_W-1:BYTE_W];
         SRC_ADDR_LO: byte_sel = addr_ff[BYTE_W-1:0];
         SRC_DATA:    byte_sel = (cnt_ff < CNT_W'(fill_ff)) ? rd_ff : '0;
         SRC_TOTAL:   byte_sel = quo_ff[BYTE_W-1:0];
         SRC_INDEX:   byte_sel = index_ff;
         SRC_CRC_HI:  byte_sel = crc_ff[CRC_W-1:BYTE_W];
         SRC_CRC_LO:  byte_sel = crc_ff[BYTE_W-1:0];
         default:     byte_sel = '0;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      left_in      = left_ff;
      addr_in      = addr_ff;
      index_in     = index_ff;
      active_in    = active_ff;
      quo_in       = quo_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      kind_in      = kind_ff;
      frame_end_in = frame_end_ff;

      if (acc_fire) begin
         cnt_in = '0;
         if (req_chan.op == OP_START) begin
            fill_in = '0;
            if (bad_len) begin
               active_in = 1'b0;
            end else begin
               addr_in   = req_chan.dest_addr;
               left_in   = req_chan.msg_length;
               index_in  = BYTE_W'(1);
               active_in = 1'b1;
               quo_in    = DIVD_W'(req_chan.msg_length) + DIVD_W'(SLICE_BYTES - 1);
            end
         end else if (active_ff) begin
            fill_in = fill_ff + FILL_W'(1);
            left_in = left_ff - LEN_W'(1);
         end
      end else if (status.go) begin
         if (cw.cnt_inc) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (cw.div_step) begin
            quo_in = DIVD_W'(div_prod >> RCP_SH);
         end
         if (cw.crc_init) begin
            crc_in = CRC_INIT;
         end else if (cw.crc_upd) begin
            crc_in = crc16_byte(crc_ff, byte_sel);
         end
         if (cw.frame_done) begin
            index_in = index_ff + BYTE_W'(1);
            fill_in  = '0;
            if (left_ff == '0) begin
               active_in = 1'b0;
            end
         end
      end

      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = byte_sel;
         kind_in      = (cw.src == SRC_REJ);
         frame_end_in = cw.frame_end;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rd_addr = (cnt_in < CNT_W'(SLICE_BYTES)) ? cnt_in[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (acc_fire && data_ok) begin
         mem[fill_ff[IDX_W-1:0]] <= req_chan.data_byte;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         fill_ff      <= '0;
         left_ff      <= '0;
         addr_ff      <= '0;
         index_ff     <= BYTE_W'(1);
         active_ff    <= 1'b0;
         quo_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         addr_ff      <= addr_in;
         index_ff     <= index_in;
         active_ff    <= active_in;
         quo_ff       <= quo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      out_byte_ff  <= out_byte_in;
      kind_ff      <= kind_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.kind      = kind_ff;
   assign rsp_chan.frame_end = frame_end_ff;

endmodule

/* sim/tb_message_slicer_crc16_framer_top.sv */
// Self-checking testbench for message_slicer_crc16_framer_top: directed and random items,
// a predictor of the frames and rejections, and valid/ready drivers with random stalls.
// Depends on msf_pkg, msf_chan_if and the framer RTL.
module tb_message_slicer_crc16_framer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msf_pkg::*;

   localparam int SLICE_LEN   = SLICE_BYTES_DEF;
   localparam int MAX_LEN     = MAX_LENGTH_DEF;
   localparam int FRAME_LEN   = SLICE_LEN + 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;
   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] dest_addr;
      logic [LEN_W-1:0]  msg_length;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              kind;
      logic              frame_end;
   } frame_byte_type;

   bit   clock;
   logic reset = 1'b1;

   msf_req_if req_if ();
   msf_rsp_if rsp_if ();

   message_slicer_crc16_framer_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   req_item_type   pending_items[$];
   frame_byte_type frame_bytes_due[$];
   int             n_items;
   int             n_accepted;
   int             n_mismatch;
   int             n_cycles;
   bit             req_taken;
   int             hold_left;
   bit             hold_done;

   // predictor state
   logic [BYTE_W-1:0] slice_buf [SLICE_LEN];
   int                fill;
   logic [7:0]        slice_no;
   logic [7:0]        slice_cnt;
   logic [LEN_W-1:0]  left;
   logic [ADDR_W-1:0] tgt_addr;
   bit                msg_open;

   task automatic push_start(input logic [ADDR_W-1:0] addr, input int len);
      req_item_type it;
      it.op         = OP_START;
      it.dest_addr  = addr;
      it.msg_length = LEN_W'(len);
      it.data_byte  = BYTE_W'($urandom_range(0, 255));
      pending_items.push_back(it);
   endtask

   task automatic push_data(input logic [BYTE_W-1:0] b);
      req_item_type it;
      it.op         = OP_DATA;
      it.dest_addr  = ADDR_W'($urandom_range(0, 65535));
      it.msg_length = LEN_W'($urandom_range(0, 4095));
      it.data_byte  = b;
      pending_items.push_back(it);
   endtask

   task automatic slicer_predict(input req_item_type it);
      logic [BYTE_W-1:0] fr [FRAME_LEN];
      logic [CRC_W-1:0]  crc;
      frame_byte_type    e;
      if (it.op == OP_START) begin
         if (it.msg_length == 0 || int'(it.msg_length) >= MAX_LEN) begin
            msg_open = 1'b0;
            fill = 0;
            e.out_byte  = '0;
            e.kind      = KIND_REJECT;
            e.frame_end = 1'b1;
            frame_bytes_due.push_back(e);
         end else begin
            tgt_addr  = it.dest_addr;
            left      = it.msg_length;
            slice_cnt = 8'((int'(it.msg_length) + SLICE_LEN - 1) / SLICE_LEN);
            slice_no  = 8'd1;
            fill      = 0;
            msg_open  = 1'b1;
         end
      end else if (msg_open) begin
         if (fill < SLICE_LEN) slice_buf[fill] = it.data_byte;
         fill++;
         left--;
         if (fill >= SLICE_LEN || left == 0) begin
            fr[0] = HDR_SYNC;
            fr[1] = HDR_LEN;
            fr[2] = tgt_addr[15:8];
            fr[3] = tgt_addr[7:0];
            for (int i = 0; i < SLICE_LEN; i++) fr[4+i] = (i < fill) ? slice_buf[i] : '0;
            fr[4+SLICE_LEN] = slice_cnt;
            fr[5+SLICE_LEN] = slice_no;
            crc = CRC_INIT;
            for (int i = 4; i < 6 + SLICE_LEN; i++) begin
               crc = crc ^ {8'h00, fr[i]};
               for (int b = 0; b < 8; b++) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
            fr[6+SLICE_LEN] = crc[15:8];
            fr[7+SLICE_LEN] = crc[7:0];
            for (int i = 0; i < FRAME_LEN; i++) begin
               e.out_byte  = fr[i];
               e.kind      = KIND_FRAME;
               e.frame_end = (i == FRAME_LEN - 1);
               frame_bytes_due.push_back(e);
            end
            slice_no = slice_no + 8'd1;
            fill = 0;
            if (left == 0) msg_open = 1'b0;
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin
      int idle;
      idle = (n_accepted < n_items / 3) ? 27 : (n_accepted < 2 * n_items / 3) ? 86 : 0;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle) begin
            req_if.valid      <= 1'b1;
            req_if.op         <= pending_items[0].op;
            req_if.dest_addr  <= pending_items[0].dest_addr;
            req_if.msg_length <= pending_items[0].msg_length;
            req_if.data_byte  <= pending_items[0].data_byte;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_item_type it;
      req_taken = !reset && req_if.valid && req_if.ready;
      if (req_taken) begin
         it = pending_items.pop_front();
         slicer_predict(it);
         n_accepted++;
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(negedge clock) begin
      int idle;
      idle = (n_accepted < n_items / 3) ? 86 : (n_accepted < 2 * n_items / 3) ? 27 : 0;
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && n_accepted >= 60) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= idle);
      end
   end

   // response monitor
   always @(posedge clock) begin
      frame_byte_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected item: out_byte %0h kind %0b frame_end %0b",
                   rsp_if.out_byte, rsp_if.kind, rsp_if.frame_end);
            n_mismatch++;
         end else begin
            e = frame_bytes_due.pop_front();
            if (rsp_if.out_byte !== e.out_byte) begin
               $error("out_byte: expected %0h, actual %0h", e.out_byte, rsp_if.out_byte);
               n_mismatch++;
            end
            if (rsp_if.kind !== e.kind) begin
               $error("kind: expected %0b, actual %0b", e.kind, rsp_if.kind);
               n_mismatch++;
            end
            if (rsp_if.frame_end !== e.frame_end) begin
               $error("frame_end: expected %0b, actual %0b", e.frame_end, rsp_if.frame_end);
               n_mismatch++;
            end
         end
      end
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("message_slicer_crc16_framer_top regression: fail");
         $finish;
      end
   end

   initial begin
      int count;
      int r;
      int len;
      int k;
      req_if.valid      = 1'b0;
      req_if.op         = OP_START;
      req_if.dest_addr  = '0;
      req_if.msg_length = '0;
      req_if.data_byte  = '0;
      rsp_if.ready      = 1'b0;
      fill      = 0;
      slice_no  = 8'd1;
      slice_cnt = '0;
      left      = '0;
      tgt_addr  = '0;
      msg_open  = 1'b0;

      // directed: rejections, stray bytes, longest valid length, restarts, one-byte slice
      push_start(ADDR_W'($urandom_range(0, 65535)), 0);
      push_data(8'h3c);
      push_start(16'h0000, MAX_LEN - 1);
      for (int i = 0; i < SLICE_LEN; i++) push_data((i % 2) ? 8'hff : 8'h00);
      push_start(16'hffff, MAX_LEN);
      push_data(8'h81);
      push_start(16'hffff, 2);
      push_data(8'h5a);
      push_start(16'h8001, 1);
      push_data(8'hff);
      push_start(16'h1234, 4095);

      count = pending_items.size();
      while (count < 310) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            len = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 30) : $urandom_range(31, 100);
            push_start(ADDR_W'($urandom_range(0, 65535)), len);
            for (int i = 0; i < len; i++) push_data(BYTE_W'($urandom_range(0, 255)));
            count += 1 + len;
         end else if (r < 85) begin
            // cut short by the next start
            len = $urandom_range(1, MAX_LEN - 1);
            k = $urandom_range(0, (len - 1 < 20) ? len - 1 : 20);
            push_start(ADDR_W'($urandom_range(0, 65535)), len);
            for (int i = 0; i < k; i++) push_data(BYTE_W'($urandom_range(0, 255)));
            count += 1 + k;
         end else if (r < 93) begin
            len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN, 4095);
            push_start(ADDR_W'($urandom_range(0, 65535)), len);
            count++;
         end else begin
            push_data(BYTE_W'($urandom_range(0, 255)));
            count++;
         end
      end
      n_items = pending_items.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || frame_bytes_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (n_mismatch == 0 && frame_bytes_due.size() == 0) begin
         $display("message_slicer_crc16_framer_top regression: pass");
      end else begin
         $display("message_slicer_crc16_framer_top regression: fail");
      end
      $finish;
   end

endmodule
